// ===== design/rram_pkg.sv =====
package rram_pkg;

  // Widths of the item fields and the configuration registers.
  localparam int PX_W      = 12;
  localparam int ALPHA_W   = 8;
  localparam int DIM_REG_W = 13;
  localparam int CR_W      = 21;
  localparam int IDX_W     = 2;

  // Default build: 4096 pixel sides, lengths in 1/256 pixel.
  localparam int DEF_MAX_DIM   = 4096;
  localparam int DEF_FRAC_BITS = 8;

  // Register stages around the square root: six in front, four behind.
  localparam int PRE_STAGES  = 6;
  localparam int POST_STAGES = 4;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CORNER_RADIUS = 2'd2
  } cfg_reg_t;

  // Width that holds every unsigned length: pixel centres and half sides.
  function automatic int len_width(input int max_dim, input int frac_bits);
    int dim_w;
    dim_w = $clog2(max_dim + 1);
    return (((dim_w - 1) > PX_W) ? (dim_w - 1) : PX_W) + frac_bits;
  endfunction

  // Cycles from an accepted item to its result strobe.
  function automatic int pipe_latency(input int max_dim, input int frac_bits);
    return PRE_STAGES + len_width(max_dim, frac_bits) + 1 + POST_STAGES;
  endfunction

endpackage

// ===== design/rram_isqrt.sv =====
module rram_isqrt #(
  parameter int RT_W = 22,
  parameter int SB_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2*RT_W-1:0] in_radicand,
  input  logic [SB_W-1:0]   in_side,
  output logic              out_valid,
  output logic [RT_W-1:0]   out_root,
  output logic [RT_W+2:0]   out_rem,
  output logic [SB_W-1:0]   out_side
);

  localparam int RW = RT_W + 3;

  // One result bit per stage, most significant first.
  logic              vld_r  [RT_W];
  logic [2*RT_W-1:0] rad_r  [RT_W];
  logic [RW-1:0]     rem_r  [RT_W];
  logic [RT_W-1:0]   root_r [RT_W];
  logic [SB_W-1:0]   side_r [RT_W];

  logic              src_vld  [RT_W];
  logic [2*RT_W-1:0] src_rad  [RT_W];
  logic [RW-1:0]     src_rem  [RT_W];
  logic [RT_W-1:0]   src_root [RT_W];
  logic [SB_W-1:0]   src_side [RT_W];

  logic [2*RT_W-1:0] rad_nxt  [RT_W];
  logic [RW-1:0]     rem_nxt  [RT_W];
  logic [RT_W-1:0]   root_nxt [RT_W];

  // Each stage takes the previous stage's registers, the first takes the ports.
  always_comb begin
    for (int j = 0; j < RT_W; j++) begin
      if (j == 0) begin
        src_vld[j]  = in_valid;
        src_rad[j]  = in_radicand;
        src_rem[j]  = '0;
        src_root[j] = '0;
        src_side[j] = in_side;
      end else begin
        src_vld[j]  = vld_r[j-1];
        src_rad[j]  = rad_r[j-1];
        src_rem[j]  = rem_r[j-1];
        src_root[j] = root_r[j-1];
        src_side[j] = side_r[j-1];
      end
    end
  end

  // Restoring step: bring down two radicand bits and try root*4+1.
  always_comb begin
    logic [RW-1:0] rem_t;
    logic [RW-1:0] trial;
    for (int j = 0; j < RT_W; j++) begin
      rem_t = {src_rem[j][RW-3:0], src_rad[j][2*RT_W-1 -: 2]};
      trial = RW'({src_root[j], 2'b01});
      rad_nxt[j] = src_rad[j] << 2;
      if (rem_t >= trial) begin
        rem_nxt[j]  = rem_t - trial;
        root_nxt[j] = {src_root[j][RT_W-2:0], 1'b1};
      end else begin
        rem_nxt[j]  = rem_t;
        root_nxt[j] = {src_root[j][RT_W-2:0], 1'b0};
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < RT_W; j++) vld_r[j] <= 1'b0;
    end else begin
      for (int j = 0; j < RT_W; j++) vld_r[j] <= src_vld[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < RT_W; j++) begin
      rad_r[j]  <= rad_nxt[j];
      rem_r[j]  <= rem_nxt[j];
      root_r[j] <= root_nxt[j];
      side_r[j] <= src_side[j];
    end
  end

  assign out_valid = vld_r[RT_W-1];
  assign out_root  = root_r[RT_W-1];
  assign out_rem   = rem_r[RT_W-1];
  assign out_side  = side_r[RT_W-1];

endmodule

// ===== design/rounded_rect_alpha_mask_unit.sv =====
// Rounded-rectangle alpha mask. Each item is one pixel (column, row, alpha);
// the block scales the alpha by how much of the pixel lies inside a rectangle
// with rounded corners that covers the whole image.
// Input: an item is taken at a clock edge with start high and busy low. Busy
// is low whenever reset is released, so one pixel can be taken every cycle.
// Output: each result appears on out_alpha_out for one cycle with out_valid
// high, in the order the items came in. The receiver has no way to stall;
// nothing inside waits on it. The longest part of the pipeline is the square
// root of the squared corner distance, which resolves one root bit per
// pipeline stage (LEN_W + 1 stages), with six stages of geometry in front
// and four of coverage and scaling behind.
// Configuration: cfg_valid/cfg_ready with a register index and data; write
// only while no items are in flight. Unknown indexes are ignored.
// Reset (rst_n low, synchronous) empties the pipeline, sets width and height
// to one and the radius to zero, which passes alpha through unchanged.
module rounded_rect_alpha_mask_unit #(
  parameter int MAX_DIM   = rram_pkg::DEF_MAX_DIM,
  parameter int FRAC_BITS = rram_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rram_pkg::PX_W-1:0]     in_pixel_x,
  input  logic [rram_pkg::PX_W-1:0]     in_pixel_y,
  input  logic [rram_pkg::ALPHA_W-1:0]  in_alpha_in,
  output logic                          out_valid,
  output logic [rram_pkg::ALPHA_W-1:0]  out_alpha_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rram_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rram_pkg::CR_W-1:0]     cfg_data
);

  localparam int PX_W    = rram_pkg::PX_W;
  localparam int A_W     = rram_pkg::ALPHA_W;
  localparam int DR_W    = rram_pkg::DIM_REG_W;
  localparam int CR_W    = rram_pkg::CR_W;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int LEN_W   = rram_pkg::len_width(MAX_DIM, FRAC_BITS);
  localparam int CMP_W   = (LEN_W > CR_W) ? LEN_W : CR_W;
  localparam int RT_W    = LEN_W + 1;
  localparam int SUM_W   = 2 * LEN_W + 1;
  localparam int T_W     = LEN_W + 3;
  localparam int COV_W   = FRAC_BITS + 1;
  localparam int PROD_W  = A_W + COV_W;
  localparam int SB_W    = A_W + T_W;

  localparam logic [LEN_W-1:0] HALF_LEN = LEN_W'(1) << (FRAC_BITS - 1);
  localparam logic [T_W-1:0]   HALF_T   = T_W'(1) << (FRAC_BITS - 1);
  localparam logic [T_W-1:0]   ONE_T    = T_W'(1) << FRAC_BITS;
  localparam logic [COV_W-1:0] ONE_COV  = COV_W'(1) << FRAC_BITS;
  localparam logic [PROD_W:0]  HALF_P   = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

  // Handshakes: everything is taken whenever reset is released.
  logic accept;
  assign busy      = !rst_n;
  assign cfg_ready = rst_n;
  assign accept    = start && !busy;

  // Configuration registers.
  logic [DR_W-1:0] cfg_width_r;
  logic [DR_W-1:0] cfg_height_r;
  logic [CR_W-1:0] cfg_radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= DR_W'(1);
      cfg_height_r <= DR_W'(1);
      cfg_radius_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (rram_pkg::cfg_reg_t'(cfg_index))
        rram_pkg::REG_IMAGE_WIDTH:   cfg_width_r  <= cfg_data[DR_W-1:0];
        rram_pkg::REG_IMAGE_HEIGHT:  cfg_height_r <= cfg_data[DR_W-1:0];
        rram_pkg::REG_CORNER_RADIUS: cfg_radius_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Derived geometry, first level: saturated sides and half sides.
  logic [DIM_W-1:0] w_sat;
  logic [DIM_W-1:0] h_sat;
  logic [LEN_W-1:0] hw_r;
  logic [LEN_W-1:0] hh_r;
  logic             bypass_r;

  always_comb begin
    if (cfg_width_r == '0) begin
      w_sat = DIM_W'(1);
    end else if (32'(cfg_width_r) > MAX_DIM) begin
      w_sat = DIM_W'(MAX_DIM);
    end else begin
      w_sat = DIM_W'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h_sat = DIM_W'(1);
    end else if (32'(cfg_height_r) > MAX_DIM) begin
      h_sat = DIM_W'(MAX_DIM);
    end else begin
      h_sat = DIM_W'(cfg_height_r);
    end
  end

  always_ff @(posedge clk) begin
    hw_r     <= LEN_W'(w_sat) << (FRAC_BITS - 1);
    hh_r     <= LEN_W'(h_sat) << (FRAC_BITS - 1);
    bypass_r <= (cfg_radius_r == '0);
  end

  // Second level: radius clamped to half the smaller side.
  logic [LEN_W-1:0] rmax;
  logic [LEN_W-1:0] r_nxt;
  logic [LEN_W-1:0] r_r;

  always_comb begin
    rmax = (hw_r < hh_r) ? hw_r : hh_r;
    if (CMP_W'(cfg_radius_r) < CMP_W'(rmax)) begin
      r_nxt = LEN_W'(cfg_radius_r);
    end else begin
      r_nxt = rmax;
    end
  end

  // Third level: distance from the centre to where the corner arcs begin.
  logic [LEN_W-1:0] ex_r;
  logic [LEN_W-1:0] ey_r;

  always_ff @(posedge clk) begin
    r_r  <= r_nxt;
    ex_r <= hw_r - r_r;
    ey_r <= hh_r - r_r;
  end

  // Valid bits of the geometry stages and the back end.
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r;
  logic f1_v_r, f2_v_r, f3_v_r, f4_v_r;
  logic sq_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
      f4_v_r <= 1'b0;
    end else begin
      v0_r   <= accept;
      v1_r   <= v0_r;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      v5_r   <= v4_r;
      f1_v_r <= sq_valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
      f4_v_r <= f3_v_r;
    end
  end

  // Stage 0: item registers.
  logic [PX_W-1:0] px0_r;
  logic [PX_W-1:0] py0_r;
  logic [A_W-1:0]  a0_r;

  always_ff @(posedge clk) begin
    px0_r <= in_pixel_x;
    py0_r <= in_pixel_y;
    a0_r  <= in_alpha_in;
  end

  // Stage 1: pixel centre relative to the image centre.
  logic [LEN_W-1:0]        cx1;
  logic [LEN_W-1:0]        cy1;
  logic signed [LEN_W:0]   dx1_r;
  logic signed [LEN_W:0]   dy1_r;
  logic [A_W-1:0]          a1_r;

  assign cx1 = (LEN_W'(px0_r) << FRAC_BITS) | HALF_LEN;
  assign cy1 = (LEN_W'(py0_r) << FRAC_BITS) | HALF_LEN;

  always_ff @(posedge clk) begin
    dx1_r <= $signed({1'b0, cx1}) - $signed({1'b0, hw_r});
    dy1_r <= $signed({1'b0, cy1}) - $signed({1'b0, hh_r});
    a1_r  <= a0_r;
  end

  // Stage 2: absolute offsets.
  logic [LEN_W-1:0] ax2_r;
  logic [LEN_W-1:0] ay2_r;
  logic [A_W-1:0]   a2_r;

  always_ff @(posedge clk) begin
    ax2_r <= dx1_r[LEN_W] ? LEN_W'(-dx1_r) : LEN_W'(dx1_r);
    ay2_r <= dy1_r[LEN_W] ? LEN_W'(-dy1_r) : LEN_W'(dy1_r);
    a2_r  <= a1_r;
  end

  // Stage 3: offsets past the start of the corner arcs.
  logic signed [LEN_W:0] qx3_r;
  logic signed [LEN_W:0] qy3_r;
  logic [A_W-1:0]        a3_r;

  always_ff @(posedge clk) begin
    qx3_r <= $signed({1'b0, ax2_r}) - $signed({1'b0, ex_r});
    qy3_r <= $signed({1'b0, ay2_r}) - $signed({1'b0, ey_r});
    a3_r  <= a2_r;
  end

  // Stage 4: squares of the outside parts, inside distance on the side.
  logic [LEN_W-1:0]        ox4;
  logic [LEN_W-1:0]        oy4;
  logic signed [LEN_W:0]   qmax4;
  logic [2*LEN_W-1:0]      sqx4_r;
  logic [2*LEN_W-1:0]      sqy4_r;
  logic signed [LEN_W:0]   m4_r;
  logic [A_W-1:0]          a4_r;

  assign ox4   = qx3_r[LEN_W] ? '0 : qx3_r[LEN_W-1:0];
  assign oy4   = qy3_r[LEN_W] ? '0 : qy3_r[LEN_W-1:0];
  assign qmax4 = (qx3_r > qy3_r) ? qx3_r : qy3_r;

  always_ff @(posedge clk) begin
    sqx4_r <= ox4 * ox4;
    sqy4_r <= oy4 * oy4;
    m4_r   <= qmax4[LEN_W] ? qmax4 : '0;
    a4_r   <= a3_r;
  end

  // Stage 5: sum of squares, and one half plus radius minus inside distance.
  logic [SUM_W-1:0]      sum5_r;
  logic signed [T_W-1:0] t5_r;
  logic [A_W-1:0]        a5_r;

  always_ff @(posedge clk) begin
    sum5_r <= SUM_W'(sqx4_r) + SUM_W'(sqy4_r);
    t5_r   <= $signed(T_W'(r_r)) + $signed(HALF_T) - T_W'(m4_r);
    a5_r   <= a4_r;
  end

  // Square root, one bit per stage, with alpha and the offset riding along.
  logic [RT_W-1:0] sq_root;
  logic [RT_W+2:0] sq_rem;
  logic [SB_W-1:0] sq_side;

  rram_isqrt #(
    .RT_W (RT_W),
    .SB_W (SB_W)
  ) u_isqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (v5_r),
    .in_radicand ((2*RT_W)'(sum5_r)),
    .in_side     ({a5_r, t5_r}),
    .out_valid   (sq_valid),
    .out_root    (sq_root),
    .out_rem     (sq_rem),
    .out_side    (sq_side)
  );

  // Back end 1: round the root to nearest.
  logic [RT_W:0]         len1_r;
  logic signed [T_W-1:0] t1_r;
  logic [A_W-1:0]        a_f1_r;

  always_ff @(posedge clk) begin
    len1_r <= (RT_W + 1)'(sq_root) + (RT_W + 1)'(sq_rem > (RT_W + 3)'(sq_root));
    t1_r   <= $signed(sq_side[T_W-1:0]);
    a_f1_r <= sq_side[SB_W-1 -: A_W];
  end

  // Back end 2: coverage clamped to zero..one.
  logic signed [T_W-1:0] cdiff;
  logic [COV_W-1:0]      cov_nxt;
  logic [COV_W-1:0]      cov2_r;
  logic [A_W-1:0]        a_f2_r;

  always_comb begin
    cdiff = t1_r - $signed(T_W'(len1_r));
    if (cdiff[T_W-1]) begin
      cov_nxt = '0;
    end else if (cdiff > $signed(ONE_T)) begin
      cov_nxt = ONE_COV;
    end else begin
      cov_nxt = cdiff[COV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    cov2_r <= cov_nxt;
    a_f2_r <= a_f1_r;
  end

  // Back end 3: alpha times coverage.
  logic [PROD_W-1:0] prod3_r;
  logic [A_W-1:0]    a_f3_r;

  always_ff @(posedge clk) begin
    prod3_r <= PROD_W'(a_f2_r) * PROD_W'(cov2_r);
    a_f3_r  <= a_f2_r;
  end

  // Back end 4: round to nearest, or pass alpha through when unmasked.
  logic [PROD_W:0]  rnd4;
  logic [A_W-1:0]   alpha4_r;

  assign rnd4 = (PROD_W + 1)'(prod3_r) + HALF_P;

  always_ff @(posedge clk) begin
    alpha4_r <= bypass_r ? a_f3_r : rnd4[FRAC_BITS + A_W - 1 -: A_W];
  end

  assign out_valid     = f4_v_r;
  assign out_alpha_out = alpha4_r;

endmodule

// ===== design/rram_checker.sv =====
module rram_checker #(
  parameter int MAX_DIM   = rram_pkg::DEF_MAX_DIM,
  parameter int FRAC_BITS = rram_pkg::DEF_FRAC_BITS
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [rram_pkg::ALPHA_W-1:0]  in_alpha_in,
  input logic                          out_valid,
  input logic [rram_pkg::ALPHA_W-1:0]  out_alpha_out
);

  localparam int LAT = rram_pkg::pipe_latency(MAX_DIM, FRAC_BITS);

  logic taken;
  assign taken = start && !busy;

  // Every item taken gives its result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    taken |-> ##LAT out_valid)
    else $error("item taken without a result after the pipeline latency");

  // No result strobe without an item taken the pipeline latency before.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(taken, LAT))
    else $error("result strobe without a matching item");

  // A fully transparent pixel stays fully transparent.
  a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_alpha_in, LAT) == '0)) |-> (out_alpha_out == '0))
    else $error("zero alpha item gave a non-zero result");

endmodule

bind rounded_rect_alpha_mask_unit rram_checker #(
  .MAX_DIM   (MAX_DIM),
  .FRAC_BITS (FRAC_BITS)
) u_rram_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_alpha_in   (in_alpha_in),
  .out_valid     (out_valid),
  .out_alpha_out (out_alpha_out)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int PX_W = rram_pkg::PX_W;
  localparam int ALPHA_W = rram_pkg::ALPHA_W;
  localparam int DIM_REG_W = rram_pkg::DIM_REG_W;
  localparam int CR_W = rram_pkg::CR_W;
  localparam int IDX_W = rram_pkg::IDX_W;
  localparam int DEF_MAX_DIM = rram_pkg::DEF_MAX_DIM;
  localparam int DEF_FRAC_BITS = rram_pkg::DEF_FRAC_BITS;
  localparam int ONE_Q = 1 << DEF_FRAC_BITS;
  localparam int HALF_Q = ONE_Q / 2;
  localparam int PIPE_LAT = rram_pkg::pipe_latency(DEF_MAX_DIM, DEF_FRAC_BITS);
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [CR_W-1:0] RADIUS_MAX = '1;

  typedef struct packed {
    logic [PX_W-1:0]    x;
    logic [PX_W-1:0]    y;
    logic [ALPHA_W-1:0] alpha;
  } pixel_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [PX_W-1:0] in_pixel_x = '0;
  logic [PX_W-1:0] in_pixel_y = '0;
  logic [ALPHA_W-1:0] in_alpha_in = '0;
  logic out_valid;
  logic [ALPHA_W-1:0] out_alpha_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CR_W-1:0] cfg_data = '0;

  // Pixels waiting to be sent and alphas waiting to come back.
  pixel_t pending_pixels[$];
  logic [ALPHA_W-1:0] expected_alpha[$];

  // Shadow copy of the mask registers, as they stand after reset.
  logic [DIM_REG_W-1:0] cur_width = 1;
  logic [DIM_REG_W-1:0] cur_height = 1;
  logic [CR_W-1:0] cur_radius = '0;

  int gap_pct = 0;
  int gap_left = 0;
  int err_count = 0;

  rounded_rect_alpha_mask_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .in_alpha_in  (in_alpha_in),
    .out_valid    (out_valid),
    .out_alpha_out(out_alpha_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // A side of zero counts as one pixel; anything above the maximum is clipped.
  function automatic int eff_dim(input logic [DIM_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DEF_MAX_DIM) return DEF_MAX_DIM;
    return int'(v);
  endfunction

  // Alpha scaled by the share of the pixel that lies inside the rounded rectangle.
  function automatic logic [ALPHA_W-1:0] masked_alpha(input pixel_t p);
    longint hw, hh, r, cx, cy, qx, qy, ox, oy, mx, d, cov, sum, rem, root, bitv;
    if (cur_radius == 0) return p.alpha;
    hw = longint'(eff_dim(cur_width)) * HALF_Q;
    hh = longint'(eff_dim(cur_height)) * HALF_Q;
    r = longint'(cur_radius);
    if (r > hw) r = hw;
    if (r > hh) r = hh;
    cx = longint'(p.x) * ONE_Q + HALF_Q;
    cy = longint'(p.y) * ONE_Q + HALF_Q;
    qx = ((cx > hw) ? cx - hw : hw - cx) - (hw - r);
    qy = ((cy > hh) ? cy - hh : hh - cy) - (hh - r);
    ox = (qx > 0) ? qx : 0;
    oy = (qy > 0) ? qy : 0;
    // Length of the corner offset: integer square root, then rounded.
    sum = ox * ox + oy * oy;
    rem = sum;
    root = 0;
    bitv = longint'(1) << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (sum - root * root > root) root = root + 1;
    mx = (qx > qy) ? qx : qy;
    if (mx > 0) mx = 0;
    d = root + mx - r;
    cov = HALF_Q - d;
    if (cov < 0) cov = 0;
    if (cov > ONE_Q) cov = ONE_Q;
    return ALPHA_W'((longint'(p.alpha) * cov + HALF_Q) >> DEF_FRAC_BITS);
  endfunction

  // Coordinate biased towards the corners and edges of a side of the given span.
  function automatic logic [PX_W-1:0] pick_coord(input int span);
    int off;
    case ($urandom_range(0, 9))
      0: return PX_W'($urandom_range(0, 4095));
      1, 2, 3, 4: begin
        off = $urandom_range(0, (span > 24) ? 24 : span - 1);
        return PX_W'(($urandom_range(0, 1) == 1) ? off : span - 1 - off);
      end
      5: return PX_W'((span > 4095) ? 4095 : span);
      default: return PX_W'($urandom_range(0, span - 1));
    endcase
  endfunction

  // Raw register value for a side, including zero and oversized values.
  function automatic logic [CR_W-1:0] rand_dim();
    logic [CR_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = CR_W'($urandom_range(4097, 8191));
      2: v = CR_W'(4096);
      3: v = CR_W'($urandom_range(1, 4096));
      default: v = CR_W'($urandom_range(1, 48));
    endcase
    if ($urandom_range(0, 3) == 0) v[CR_W-1:DIM_REG_W] = (CR_W - DIM_REG_W)'($urandom);
    return v;
  endfunction

  task automatic add_pixel(input int x, input int y, input int a);
    pending_pixels.push_back(pixel_t'({PX_W'(x), PX_W'(y), ALPHA_W'(a)}));
  endtask

  // Leaves the write valid high so that writes can follow back to back.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rram_pkg::REG_IMAGE_WIDTH: cur_width = data[DIM_REG_W-1:0];
      rram_pkg::REG_IMAGE_HEIGHT: cur_height = data[DIM_REG_W-1:0];
      rram_pkg::REG_CORNER_RADIUS: cur_radius = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CR_W-1:0] w, input logic [CR_W-1:0] h,
                           input logic [CR_W-1:0] rad);
    write_reg(rram_pkg::REG_IMAGE_WIDTH, w);
    write_reg(rram_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(rram_pkg::REG_CORNER_RADIUS, rad);
    cfg_valid <= 1'b0;
  endtask

  // Returns once every queued pixel has been taken and its alpha has come back.
  task automatic drain();
    do @(posedge clk);
    while (pending_pixels.size() != 0 || start || expected_alpha.size() != 0);
  endtask

  // Pixel driver: holds an item until it is taken, with bursts of idle cycles.
  always @(posedge clk) begin : pixel_driver
    pixel_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        expected_alpha.push_back(masked_alpha(pixel_t'({in_pixel_x, in_pixel_y, in_alpha_in})));
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          nxt = pending_pixels.pop_front();
          in_pixel_x <= nxt.x;
          in_pixel_y <= nxt.y;
          in_alpha_in <= nxt.alpha;
          start <= 1'b1;
          if ($urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 17);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each strobe is matched against the oldest expected alpha.
  always @(posedge clk) begin : alpha_monitor
    logic [ALPHA_W-1:0] want;
    if (rst_n && out_valid) begin
      if (expected_alpha.size() == 0) begin
        $error("alpha_out: expected nothing, actual %0d", out_alpha_out);
        err_count++;
      end else begin
        want = expected_alpha.pop_front();
        if (out_alpha_out !== want) begin
          $error("alpha_out: expected %0d, actual %0d", want, out_alpha_out);
          err_count++;
        end
      end
    end
  end

  // Stimulus: directed corner cases first, then randomised mask settings.
  initial begin : stimulus
    int ew, eh, half_side;
    logic [CR_W-1:0] w_data, h_data, rad;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a zero radius passes alpha straight through.
    gap_pct = 10;
    add_pixel(0, 0, 0);
    add_pixel(4095, 4095, 255);
    add_pixel(0, 4095, 255);
    drain();

    // Small image with three-pixel corners: corners, edges, centre and outside.
    configure(16, 8, 3 * ONE_Q);
    add_pixel(0, 0, 255);
    add_pixel(15, 0, 255);
    add_pixel(0, 7, 255);
    add_pixel(15, 7, 255);
    add_pixel(8, 4, 255);
    add_pixel(0, 4, 200);
    add_pixel(16, 8, 255);
    add_pixel(4095, 4095, 255);
    add_pixel(1, 1, 0);
    add_pixel(1, 0, 1);
    drain();

    // A write to an unknown index must leave the mask settings alone.
    write_reg(REG_UNUSED, RADIUS_MAX);
    cfg_valid <= 1'b0;
    add_pixel(0, 0, 255);
    add_pixel(1, 1, 255);
    drain();

    // Width of zero, height beyond the maximum, radius far too large.
    configure(0, RADIUS_MAX, RADIUS_MAX);
    add_pixel(0, 0, 255);
    add_pixel(0, 2048, 128);
    add_pixel(0, 4095, 255);
    add_pixel(1, 0, 255);
    drain();

    // Largest image with the smallest non-zero radius.
    configure(4096, 4096, 1);
    add_pixel(0, 0, 255);
    add_pixel(4095, 4095, 255);
    add_pixel(2048, 2048, 77);
    drain();

    // Random settings; the final phase runs without idle cycles.
    for (int ph = 0; ph < 12; ph++) begin
      w_data = rand_dim();
      h_data = rand_dim();
      ew = eff_dim(w_data[DIM_REG_W-1:0]);
      eh = eff_dim(h_data[DIM_REG_W-1:0]);
      half_side = ((ew < eh) ? ew : eh) * HALF_Q;
      case ($urandom_range(0, 6))
        0: rad = '0;
        1: rad = CR_W'($urandom_range(1, 255));
        2, 3: rad = CR_W'($urandom_range(1, half_side));
        4: rad = CR_W'(half_side);
        5: rad = CR_W'($urandom_range(half_side, RADIUS_MAX));
        default: rad = RADIUS_MAX;
      endcase
      configure(w_data, h_data, rad);
      if (ph == 11) begin
        gap_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: gap_pct = 0;
          1: gap_pct = 5;
          2: gap_pct = 20;
          default: gap_pct = 50;
        endcase
      end
      for (int i = 0; i < 64; i++) begin
        add_pixel(pick_coord(ew), pick_coord(eh),
                  ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 255));
      end
      drain();
    end

    // Let any stray strobe show itself before the verdict.
    repeat (PIPE_LAT + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS rounded_rect_alpha_mask_unit");
    end else begin
      $display("FAIL rounded_rect_alpha_mask_unit");
    end
    $finish;
  end

  // Watchdog for a hung pipeline or a lost result.
  initial begin : watchdog
    #(2_000_000);
    $display("FAIL rounded_rect_alpha_mask_unit");
    $finish;
  end

endmodule
